// ===== hdl/xor_range_query_tree_unit_macros.svh =====
// assertion macros for the xor range query tree unit checker
// every macro samples on clk and is disabled while rst_n is low
`ifndef XOR_RANGE_QUERY_TREE_UNIT_MACROS_SVH
`define XOR_RANGE_QUERY_TREE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define XRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define XRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/xrq_pkg.sv =====
// shared types and constants for the xor range query tree unit
// no dependencies; used by the top level and its checker
`default_nettype none

package xrq_pkg;

    // field widths
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 16;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + INDEX_W;
    localparam int FIRST_LSB = VAL_LSB + VALUE_W;
    localparam int LAST_LSB  = FIRST_LSB + INDEX_W;
    localparam int IN_BITS   = LAST_LSB + INDEX_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output tdata holds xor_total alone
    localparam int M_TDATA_W = VALUE_W;

    // largest count the register can express
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

// ===== hdl/xor_range_query_tree_unit.sv =====
// xor range query segment tree, node words in one simple dual-port memory; depends on xrq_pkg
// one item at a time; an item is taken in idle and the input reopens when its walk ends
// write: walks down to the leaf, writes it, then climbs back rewriting each parent up to the root
// query: walks the range boundaries folding node reads into the result, then waits in S_QOUT,
//        longer while the previous result stalls in the output register
// reset: element_count returns to MAX_ELEMENTS mod 2**COUNT_W; all 4*MAX_ELEMENTS words are cleared
`default_nettype none

module xor_range_query_tree_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // index[9:0], value[25:10], range_first[35:26], range_last[45:36], zero pad
    input  wire logic [xrq_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[0]
    input  wire logic                            s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // xor_total[15:0]
    output logic      [xrq_pkg::M_TDATA_W-1:0]   m_tdata,
    // nonzero[0]
    output logic                                 m_tuser,
    // element_count register write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [xrq_pkg::COUNT_W-1:0]     cfg_data
);

    import xrq_pkg::*;

    localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int CAP        = (MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS;
    localparam logic [COUNT_W-1:0]  CAP_L      = COUNT_W'(CAP);
    localparam logic [COUNT_W-1:0]  COUNT_RST  = COUNT_W'(MAX_ELEMENTS % (COUNT_MAX + 1));
    localparam logic [NODE_AW-1:0]  LAST_NODE  = NODE_AW'(NODE_DEPTH - 1);
    localparam logic [NODE_AW-1:0]  NODE_ONE   = NODE_AW'(1);
    localparam logic [COUNT_W-1:0]  COUNT_ONE  = COUNT_W'(1);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_WDESC  = 8'b0000_0100,
        S_WASC   = 8'b0000_1000,
        S_QDESC  = 8'b0001_0000,
        S_QLEFT  = 8'b0010_0000,
        S_QRIGHT = 8'b0100_0000,
        S_QOUT   = 8'b1000_0000
    } state_t;

    // control registers
    state_t               state_reg, state_next;
    logic [NODE_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                 rd_valid_reg;
    logic                 m_tvalid_reg;
    logic [COUNT_W-1:0]   count_reg;

    // walk registers
    logic [COUNT_W-1:0]   lo_reg, lo_next;
    logic [COUNT_W-1:0]   hi_reg, hi_next;
    logic [NODE_AW-1:0]   node_reg, node_next;
    logic [COUNT_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0]   last_reg, last_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [NODE_AW-1:0]   rnode_reg, rnode_next;
    logic [COUNT_W-1:0]   rlo_reg, rlo_next;
    logic [COUNT_W-1:0]   rhi_reg, rhi_next;
    logic [VALUE_W-1:0]   m_tdata_reg;
    logic                 m_tuser_reg;

    // node memory
    logic [VALUE_W-1:0]   node_mem [NODE_DEPTH];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 wr_en;
    logic [NODE_AW-1:0]   wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [NODE_AW-1:0]   rd_addr;
    logic                 out_load;

    // input fields
    opcode_t              in_opcode;
    logic [COUNT_W-1:0]   in_at;
    logic [VALUE_W-1:0]   in_value;
    logic [COUNT_W-1:0]   in_first;
    logic [COUNT_W-1:0]   in_last;

    // derived values
    logic [COUNT_W-1:0]   active_cnt;
    logic [COUNT_W-1:0]   cnt_m1;
    logic [COUNT_W-1:0]   last_clip;
    logic [COUNT_W:0]     span_sum;
    logic [COUNT_W-1:0]   mid;
    logic [COUNT_W-1:0]   mid_inc;
    logic [NODE_AW-1:0]   left_child;
    logic [NODE_AW-1:0]   right_child;
    logic [NODE_AW-1:0]   sibling;
    logic [NODE_AW-1:0]   parent;
    logic [NODE_AW-1:0]   parent_sib;
    logic [VALUE_W-1:0]   up_value;

    // field unpacking
    assign in_opcode = opcode_t'(s_tuser);
    assign in_at     = {1'b0, s_tdata[IDX_LSB +: INDEX_W]};
    assign in_value  = s_tdata[VAL_LSB +: VALUE_W];
    assign in_first  = {1'b0, s_tdata[FIRST_LSB +: INDEX_W]};
    assign in_last   = {1'b0, s_tdata[LAST_LSB +: INDEX_W]};

    // element count in use and query clipping
    assign active_cnt = (count_reg > CAP_L) ? CAP_L : count_reg;
    assign cnt_m1     = active_cnt - COUNT_ONE;
    assign last_clip  = (in_last > cnt_m1) ? cnt_m1 : in_last;

    // split point of the current node
    assign span_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = span_sum[COUNT_W:1];
    assign mid_inc  = mid + COUNT_ONE;

    // tree neighbors of the current node
    assign left_child  = {node_reg[NODE_AW-2:0], 1'b1};
    assign right_child = left_child + NODE_ONE;
    assign sibling     = node_reg[0] ? (node_reg + NODE_ONE) : (node_reg - NODE_ONE);
    assign parent      = (node_reg - NODE_ONE) >> 1;
    assign parent_sib  = parent[0] ? (parent + NODE_ONE) : (parent - NODE_ONE);
    assign up_value    = val_reg ^ rd_data_reg;

    // next-state and memory access logic
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        node_next    = node_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        val_next     = val_reg;
        rnode_next   = rnode_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        acc_next     = acc_reg ^ (rd_valid_reg ? rd_data_reg : '0);
        wr_en        = 1'b0;
        wr_addr      = node_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = node_reg;
        out_load     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + NODE_ONE;
                if (clr_cnt_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    lo_next   = '0;
                    hi_next   = cnt_m1;
                    node_next = '0;
                    if (in_opcode == OP_WRITE)
                    begin
                        pos_next = in_at;
                        val_next = in_value;
                        // out of range writes are dropped here
                        if ((active_cnt != '0) && (in_at < active_cnt))
                        begin
                            state_next = S_WDESC;
                        end
                    end
                    else
                    begin
                        pos_next  = in_first;
                        last_next = last_clip;
                        acc_next  = '0;
                        if ((active_cnt == '0) || (in_first > last_clip))
                        begin
                            state_next = S_QOUT;
                        end
                        else
                        begin
                            state_next = S_QDESC;
                        end
                    end
                end
            end

            // walk down to the leaf of the written element
            S_WDESC:
            begin
                if (lo_reg == hi_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = node_reg;
                    wr_data = val_reg;
                    if (node_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = sibling;
                        state_next = S_WASC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (pos_reg <= mid)
                begin
                    node_next = left_child;
                    hi_next   = mid;
                end
                else
                begin
                    node_next = right_child;
                    lo_next   = mid_inc;
                end
            end

            // climb back: parent takes new child xor sibling read last cycle;
            // the sibling read never hits the word written in the same cycle
            S_WASC:
            begin
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = up_value;
                val_next  = up_value;
                node_next = parent;
                if (parent != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent_sib;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // common path until the range splits across both children or a node lies inside it
            S_QDESC:
            begin
                if ((pos_reg <= lo_reg) && (last_reg >= hi_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = node_reg;
                    state_next = S_QOUT;
                end
                else if (last_reg <= mid)
                begin
                    node_next = left_child;
                    hi_next   = mid;
                end
                else if (pos_reg > mid)
                begin
                    node_next = right_child;
                    lo_next   = mid_inc;
                end
                else
                begin
                    node_next  = left_child;
                    hi_next    = mid;
                    rnode_next = right_child;
                    rlo_next   = mid_inc;
                    rhi_next   = hi_reg;
                    state_next = S_QLEFT;
                end
            end

            // left boundary: collect right children that lie inside the range
            S_QLEFT:
            begin
                if (pos_reg <= lo_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = node_reg;
                    node_next  = rnode_reg;
                    lo_next    = rlo_reg;
                    hi_next    = rhi_reg;
                    state_next = S_QRIGHT;
                end
                else if (pos_reg <= mid)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = right_child;
                    node_next = left_child;
                    hi_next   = mid;
                end
                else
                begin
                    node_next = right_child;
                    lo_next   = mid_inc;
                end
            end

            // right boundary: collect left children that lie inside the range
            S_QRIGHT:
            begin
                if (last_reg >= hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = node_reg;
                    state_next = S_QOUT;
                end
                else if (last_reg > mid)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = left_child;
                    node_next = right_child;
                    lo_next   = mid_inc;
                end
                else
                begin
                    node_next = left_child;
                    hi_next   = mid;
                end
            end

            // last read folds in here; wait for the output slot
            S_QOUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            count_reg    <= COUNT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            rd_valid_reg <= rd_en;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        node_reg  <= node_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        val_reg   <= val_next;
        acc_reg   <= acc_next;
        rnode_reg <= rnode_next;
        rlo_reg   <= rlo_next;
        rhi_reg   <= rhi_next;
        if (out_load)
        begin
            m_tdata_reg <= acc_next;
            m_tuser_reg <= |acc_next;
        end
    end

    // ports
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/xrq_checker.sv =====
// port-level checker for the xor range query tree unit, bound to the top level
// depends on xrq_pkg and xor_range_query_tree_unit_macros.svh
`default_nettype none

`include "xor_range_query_tree_unit_macros.svh"

module xrq_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [xrq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            m_tuser
);

    import xrq_pkg::*;

    logic write_xfer;

    assign write_xfer = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_WRITE);

    // a stalled result holds its payload
    `XRQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // the flag always matches the xor value
    `XRQ_ASSERT_SAME(a_nonzero_flag, m_tvalid, m_tuser == (m_tdata != '0), "nonzero flag disagrees with xor_total")

    // memory clearing keeps the input closed right after reset
    `XRQ_ASSERT_SAME(a_clear_blocks, $rose(rst_n), !s_tready, "input open during clearing pass")

    // a write transfer never produces a result
    `XRQ_ASSERT_NEXT(a_write_silent, write_xfer && !m_tvalid, !m_tvalid, "write produced a result")

endmodule

bind xor_range_query_tree_unit xrq_checker u_xrq_checker (.*);

`default_nettype wire
